// ----- hw/rtl/rhn_pkg.sv -----
// shared constants, request codes and the bin mapping for the rgb histogram normalizer
package rhn_pkg;

  localparam int unsigned MaxBinsDef   = 256;
  localparam int unsigned CountBitsDef = 20;
  localparam int unsigned ChanBits     = 8;
  localparam int unsigned HeightBits   = 10;
  localparam int unsigned CfgDataBits  = 10;
  localparam int unsigned NumChan      = 3;

  localparam logic [3:0] BinsLog2Min   = 4'd5;
  localparam logic [3:0] BinsLog2Max   = 4'd8;
  localparam logic [3:0] BinsLog2Reset = 4'd8;

  localparam logic [HeightBits-1:0] PlotHeightReset = 10'd400;

  // configuration register indexes
  localparam logic CfgBinsLog2   = 1'b0;
  localparam logic CfgPlotHeight = 1'b1;

  typedef enum logic [1:0] {
    ReqSample = 2'd0,
    ReqRead   = 2'd1,
    ReqClear  = 2'd2
  } req_e;

  // bin of an 8-bit channel value for 2^l bins
  function automatic logic [ChanBits-1:0] bin_of(input logic [ChanBits-1:0] v,
                                                 input logic [3:0] l);
    logic [3:0] sh;
    sh = 4'd8 - l;
    return v >> sh;
  endfunction

endpackage

// ----- hw/rtl/rgb_histogram_normalizer_unit.sv -----
// top level of the rgb histogram normalizer: histogram memories, maxima and readout sequencer
//
// Keeps one histogram per color channel (blue, green, red) of 2^bins_log2 bins, each
// bin a COUNT_BITS saturating counter, plus a running maximum per channel. A sample
// transfer (req_type 0) bumps one bin per channel through its steps: accept, memory
// read, write-back with maximum update. A read transfer (req_type 1) returns
// floor(count * plot_height / max) for each channel (0 for an empty channel or a bin
// at or above the bin count); the three quotients go one after another through a
// single shift-subtract divider, one quotient bit per cycle, before the result is
// offered. A clear transfer (req_type 2) zeroes the maxima and sweeps the three
// memories one bin per cycle; the same sweep runs after reset, and in_ready_o
// stays low until it ends. Request code 3 is taken and dropped. The block works
// on one request at a time; the result sits in an output register, so the next
// request is accepted while it waits. Configuration writes take effect from the
// next cycle and are meant to happen only while the block is idle.
module rgb_histogram_normalizer_unit import rhn_pkg::*; #(
  parameter int unsigned MAX_BINS   = MaxBinsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // configuration write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,

  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [ChanBits-1:0]    blue_i,
  input  logic [ChanBits-1:0]    green_i,
  input  logic [ChanBits-1:0]    red_i,
  input  logic [ChanBits-1:0]    bin_index_i,

  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [HeightBits-1:0]  height_blue_o,
  output logic [HeightBits-1:0]  height_green_o,
  output logic [HeightBits-1:0]  height_red_o
);

  localparam int unsigned AddrBits = $clog2(MAX_BINS);
  // largest bin count exponent the memories can hold (floor of log2)
  localparam int unsigned MaxLog2  = $clog2(MAX_BINS + 1) - 1;
  localparam int unsigned ProdBits = COUNT_BITS + HeightBits;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [1:0]            LastCh   = 2'(NumChan - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSmpRead,
    StSmpWrite,
    StRdRead,
    StRdMul,
    StRdDiv,
    StRdOut
  } state_e;

  state_e                state_q;
  logic [AddrBits-1:0]   clr_cnt_q;
  logic [AddrBits-1:0]   addr_q  [NumChan];
  logic [COUNT_BITS-1:0] rd_q    [NumChan];
  logic [COUNT_BITS-1:0] max_q   [NumChan];
  logic [HeightBits-1:0] res_q   [NumChan];
  logic [1:0]            ch_q;
  logic                  oor_q;
  logic                  out_valid_q;
  logic [HeightBits-1:0] out_b_q, out_g_q, out_r_q;

  logic [3:0]            bins_log2_q;
  logic [HeightBits-1:0] plot_height_q;

  logic [3:0]            eff_l;
  logic [COUNT_BITS-1:0] inc     [NumChan];
  logic                  mem_we;
  logic                  in_fire;
  logic                  idx_oor;

  logic                  div_start;
  logic [ProdBits-1:0]   div_dividend;
  logic                  div_done;
  logic [ProdBits-1:0]   div_quot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_log2_q   <= BinsLog2Reset;
      plot_height_q <= PlotHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBinsLog2:   bins_log2_q   <= cfg_data_i[3:0];
        CfgPlotHeight: plot_height_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // bin count exponent: clamp to 5..8, then to what the memories hold
  always_comb begin
    eff_l = bins_log2_q;
    if (eff_l < BinsLog2Min) eff_l = BinsLog2Min;
    if (eff_l > BinsLog2Max) eff_l = BinsLog2Max;
    if (eff_l > 4'(MaxLog2)) eff_l = 4'(MaxLog2);
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign idx_oor    = {1'b0, bin_index_i} >= (9'd1 << eff_l);

  // saturating increment of the bins read back
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      inc[c] = (rd_q[c] == CountMax) ? rd_q[c] : rd_q[c] + 1'b1;
    end
  end

  // memories are written by the clearing sweep and by sample write-back
  assign mem_we = (state_q == StClear) || (state_q == StSmpWrite);

  for (genvar c = 0; c < NumChan; c++) begin : g_mem
    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [AddrBits-1:0]   waddr;
    logic [COUNT_BITS-1:0] wdata;

    assign waddr = (state_q == StClear) ? clr_cnt_q : addr_q[c];
    assign wdata = (state_q == StClear) ? '0 : inc[c];

    always_ff @(posedge clk_i) begin
      if (mem_we) begin
        mem[waddr] <= wdata;
      end
      rd_q[c] <= mem[addr_q[c]];
    end
  end

  // one shared divider does the three channels in turn
  assign div_start    = (state_q == StRdMul);
  assign div_dividend = ProdBits'(rd_q[ch_q]) * ProdBits'(plot_height_q);

  rhn_divider #(
    .DVD_BITS (ProdBits),
    .DSR_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (max_q[ch_q]),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      ch_q        <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_b_q     <= '0;
      out_g_q     <= '0;
      out_r_q     <= '0;
      for (int c = 0; c < NumChan; c++) begin
        addr_q[c] <= '0;
        max_q[c]  <= '0;
        res_q[c]  <= '0;
      end
    end else begin
      // result transfer frees the output register unless a new result moves in
      if (out_valid_q && out_ready_i && (state_q != StRdOut)) out_valid_q <= 1'b0;

      case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AddrBits'(MAX_BINS - 1)) state_q <= StIdle;
        end

        StIdle: begin
          if (in_fire) begin
            case (req_e'(req_type_i))
              ReqSample: begin
                addr_q[0] <= AddrBits'(bin_of(blue_i, eff_l));
                addr_q[1] <= AddrBits'(bin_of(green_i, eff_l));
                addr_q[2] <= AddrBits'(bin_of(red_i, eff_l));
                state_q   <= StSmpRead;
              end
              ReqRead: begin
                for (int c = 0; c < NumChan; c++) begin
                  addr_q[c] <= AddrBits'(bin_index_i);
                end
                oor_q   <= idx_oor;
                ch_q    <= '0;
                state_q <= StRdRead;
              end
              ReqClear: begin
                for (int c = 0; c < NumChan; c++) begin
                  max_q[c] <= '0;
                end
                clr_cnt_q <= '0;
                state_q   <= StClear;
              end
              default: ;  // unused code, dropped
            endcase
          end
        end

        StSmpRead: state_q <= StSmpWrite;

        StSmpWrite: begin
          for (int c = 0; c < NumChan; c++) begin
            if (inc[c] > max_q[c]) max_q[c] <= inc[c];
          end
          state_q <= StIdle;
        end

        StRdRead: state_q <= StRdMul;

        StRdMul: state_q <= StRdDiv;

        StRdDiv: begin
          if (div_done) begin
            // empty channel or bin past the count reads as zero
            res_q[ch_q] <= (oor_q || (max_q[ch_q] == '0)) ? '0 : div_quot[HeightBits-1:0];
            if (ch_q == LastCh) begin
              state_q <= StRdOut;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= StRdMul;
            end
          end
        end

        StRdOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_b_q     <= res_q[0];
            out_g_q     <= res_q[1];
            out_r_q     <= res_q[2];
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign height_blue_o  = out_b_q;
  assign height_green_o = out_g_q;
  assign height_red_o   = out_r_q;

endmodule

// ----- hw/rtl/rhn_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module rhn_divider import rhn_pkg::*; #(
  parameter int unsigned DVD_BITS = CountBitsDef + HeightBits,
  parameter int unsigned DSR_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_BITS-1:0] dividend_i,
  input  logic [DSR_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [DVD_BITS-1:0] quotient_o
);

  localparam int unsigned CntBits = $clog2(DVD_BITS + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntBits-1:0]  cnt_q;
  logic [DVD_BITS-1:0] dvd_q;
  logic [DSR_BITS-1:0] dsr_q;
  logic [DSR_BITS-1:0] rem_q;

  logic [DSR_BITS:0]   rem_sh;
  logic [DSR_BITS:0]   rem_nx;
  logic                fits;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_BITS-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    rem_nx = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(DVD_BITS);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        // quotient bits shift in where dividend bits shift out
        dvd_q <= {dvd_q[DVD_BITS-2:0], fits};
        rem_q <= rem_nx[DSR_BITS-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
